/* design/vector_normalize_3d_assert.svh */
// assertion macros for the vector normaliser
`ifndef VECTOR_NORMALIZE_3D_ASSERT_SVH
`define VECTOR_NORMALIZE_3D_ASSERT_SVH
`ifndef SYNTHESIS
`define VN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define VN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define VN_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define VN_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* design/vn3d_pkg.sv */
package vn3d_pkg;
    localparam int COMP_WIDTH_DEF = 32;
    localparam int OUT_WIDTH      = 32;
    localparam int FRAC_SHIFT     = 30;
    localparam int THRESH_WIDTH   = 31;
    localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = 31'd1;
    localparam logic [0:0] REG_THRESH = 1'b0;
endpackage

/* design/vn3d_div.sv */
// pipelined restoring divider: one quotient bit per stage
// computes floor(mag * 2^30 / len), mag <= len, with a sign applied at the end
module vn3d_div #(
    parameter int LW = 49,
    parameter int TW = 8
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [LW-1:0]                 i_mag,
    input  logic [LW-1:0]                 i_len,
    input  logic                          i_neg,
    input  logic [TW-1:0]                 i_tag,
    output logic [vn3d_pkg::OUT_WIDTH-1:0] o_q,
    output logic [TW-1:0]                 o_tag
);
    import vn3d_pkg::*;

    localparam int NS = FRAC_SHIFT + 1;

    logic [LW:0]      r_rem [1:NS];
    logic [LW-1:0]    r_len [1:NS];
    logic [NS-1:0]    r_quo [1:NS];
    logic             r_neg [1:NS];
    logic [TW-1:0]    r_tag [1:NS];

    // stage 0 compares without shift, later stages shift then compare
    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [LW:0]   rem_in;
        logic [LW-1:0] len_in;
        logic [NS-1:0] quo_in;
        logic          neg_in;
        logic [TW-1:0] tag_in;
        logic [LW:0]   sh;
        logic          ge;
        if (s == 0) begin : g_first
            assign rem_in = {1'b0, i_mag};
            assign len_in = i_len;
            assign quo_in = '0;
            assign neg_in = i_neg;
            assign tag_in = i_tag;
        end else begin : g_next
            assign rem_in = r_rem[s];
            assign len_in = r_len[s];
            assign quo_in = r_quo[s];
            assign neg_in = r_neg[s];
            assign tag_in = r_tag[s];
        end
        always_comb begin
            sh = (s == 0) ? rem_in : {rem_in[LW-1:0], 1'b0};
            ge = sh >= {1'b0, len_in};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= ge ? sh - {1'b0, len_in} : sh;
                r_len[s+1] <= len_in;
                r_quo[s+1] <= {quo_in[NS-2:0], ge};
                r_neg[s+1] <= neg_in;
                r_tag[s+1] <= tag_in;
            end
        end
    end

    logic [OUT_WIDTH-1:0] q_ext;
    always_comb begin
        q_ext = OUT_WIDTH'(r_quo[NS]);
        o_q   = r_neg[NS] ? (~q_ext + 1'b1) : q_ext;
        o_tag = r_tag[NS];
    end
endmodule

/* design/vector_normalize_3d.sv */
// vector_normalize_3d: one signed Q16.16 vector per transaction in, one Q2.30 unit vector
// out, one transaction per cycle while the output is not stalled. 2 stages form magnitudes
// and squares, then a bit-serial pipelined square root with one root bit per stage
// (COMP_WIDTH+1 stages), a threshold stage, and 31 divider stages, then the output
// register. A stall freezes the whole pipeline. too_short is set and the components are
// zero when the length is not above length_threshold (APB address 0, reset 1).
module vector_normalize_3d #(
    parameter int COMP_WIDTH = vn3d_pkg::COMP_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // comp_x, comp_y, comp_z from the lowest bit up, zero fill to bytes
    input  logic [((3*COMP_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // unit_x, unit_y, unit_z from the lowest bit up
    output logic [95:0]                   m_axis_tdata,
    // too_short
    output logic                          m_axis_tuser,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [1:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import vn3d_pkg::*;
    `include "vector_normalize_3d_assert.svh"

    localparam int W   = COMP_WIDTH;
    localparam int SW  = 2*W + 2;        // sum of three squares
    localparam int RW  = W + 1;          // root width
    localparam int NR  = RW;             // root stages
    localparam int NDV = FRAC_SHIFT + 1;
    localparam int LAT = 2 + NR + 1 + NDV + 1;
    localparam int CMPW = (RW > THRESH_WIDTH) ? RW : THRESH_WIDTH;

    // configuration register
    logic [THRESH_WIDTH-1:0] r_thresh;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
        end else if (psel && penable && pwrite && paddr[1] == REG_THRESH) begin
            r_thresh <= pwdata[THRESH_WIDTH-1:0];
        end
    end
    assign pready = 1'b1;
    assign prdata = (paddr[1] == REG_THRESH) ? 32'(r_thresh) : 32'd0;

    // global enable: pipeline moves when the output is free
    logic en;
    logic [LAT:1] r_vld;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-1:1], s_axis_tvalid};
        end
    end
    assign m_axis_tvalid = r_vld[LAT];

    // stage 1: magnitudes and signs
    logic [W-1:0] r_mag [3];
    logic [2:0]   r_neg1;
    for (genvar c = 0; c < 3; c++) begin : g_mag
        logic [W-1:0] raw;
        assign raw = s_axis_tdata[c*W +: W];
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_mag[c]  <= raw[W-1] ? ~raw + 1'b1 : raw;
                r_neg1[c] <= raw[W-1];
            end
        end
    end

    // full-width squares of the magnitudes
    logic [2*W-1:0] sq [3];
    for (genvar c = 0; c < 3; c++) begin : g_sq
        assign sq[c] = {{W{1'b0}}, r_mag[c]} * {{W{1'b0}}, r_mag[c]};
    end

    // stage 2: squares summed
    logic [SW-1:0] r_sum;
    logic [W-1:0]  r_mag2 [3];
    logic [2:0]    r_neg2;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sum  <= SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);
            r_mag2 <= r_mag;
            r_neg2 <= r_neg1;
        end
    end

    // square root: one bit per stage, restoring on the running remainder
    logic [SW+1:0] r_srem [1:NR];
    logic [SW-1:0] r_sval [1:NR];
    logic [RW-1:0] r_root [1:NR];
    logic [W-1:0]  r_smag [1:NR][3];
    logic [2:0]    r_sneg [1:NR];
    for (genvar s = 0; s < NR; s++) begin : g_sqrt
        localparam int B = NR - 1 - s;
        logic [SW+1:0] rem_in;
        logic [SW-1:0] val_in;
        logic [RW-1:0] root_in;
        logic [W-1:0]  mag_in [3];
        logic [2:0]    neg_in;
        logic [SW+1:0] rem_sh;
        logic [SW+1:0] trial;
        logic [1:0]    pair;
        if (s == 0) begin : g_first
            assign rem_in  = '0;
            assign val_in  = r_sum;
            assign root_in = '0;
            assign mag_in  = r_mag2;
            assign neg_in  = r_neg2;
        end else begin : g_next
            assign rem_in  = r_srem[s];
            assign val_in  = r_sval[s];
            assign root_in = r_root[s];
            assign mag_in  = r_smag[s];
            assign neg_in  = r_sneg[s];
        end
        always_comb begin
            pair   = (2*B+1 < SW) ? val_in[2*B+1 -: 2] : {1'b0, val_in[2*B]};
            rem_sh = {rem_in[SW-1:0], pair};
            trial  = {(SW+2-RW-2)'(0), root_in, 2'b01};
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_srem[s+1] <= (rem_sh >= trial) ? rem_sh - trial : rem_sh;
                r_root[s+1] <= {root_in[RW-2:0], rem_sh >= trial};
                r_sval[s+1] <= val_in;
                r_smag[s+1] <= mag_in;
                r_sneg[s+1] <= neg_in;
            end
        end
    end

    // threshold compare
    logic           r_short;
    logic [RW-1:0]  r_len;
    logic [W-1:0]   r_tmag [3];
    logic [2:0]     r_tneg;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_short <= CMPW'(r_root[NR]) <= CMPW'(r_thresh);
            r_len   <= (r_root[NR] == '0) ? RW'(1) : r_root[NR];
            r_tmag  <= r_smag[NR];
            r_tneg  <= r_sneg[NR];
        end
    end

    // three dividers in lockstep
    logic [OUT_WIDTH-1:0] q [3];
    logic                 tag [3];
    for (genvar c = 0; c < 3; c++) begin : g_div
        vn3d_div #(.LW(RW), .TW(1)) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_mag (RW'(r_tmag[c])),
            .i_len (r_len),
            .i_neg (r_tneg[c]),
            .i_tag (r_short),
            .o_q   (q[c]),
            .o_tag (tag[c])
        );
    end

    logic [95:0] r_out;
    logic        r_oshort;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_oshort <= tag[0];
            r_out    <= tag[0] ? '0 : {q[2], q[1], q[0]};
        end
    end
    assign m_axis_tdata = r_out;
    assign m_axis_tuser = r_oshort;

    `VN_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `VN_ASSERT_IMP(a_short_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)
    `VN_ASSERT_IMP(a_ready_en, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready)
endmodule

/* tb/tb_top.sv */
module tb_top;
    import vn3d_pkg::*;

    localparam int CW = COMP_WIDTH_DEF;
    localparam int DW = ((3*CW+7)/8)*8;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [1:0] ADDR_THRESH = {REG_THRESH, 1'b0} << 1;

    typedef struct packed {
        logic [31:0] ux;
        logic [31:0] uy;
        logic [31:0] uz;
        logic        short_flag;
    } t_unit_vec;

    // fixed-point normaliser predictor and expected unit vector store
    class t_unit_vec_scoreboard;
        t_unit_vec pending[$];
        logic [THRESH_WIDTH-1:0] thresh;
        int mismatches;

        function new();
            thresh = THRESH_RESET;
            mismatches = 0;
        endfunction

        function logic [63:0] int_sqrt(logic [127:0] s);
            logic [63:0] root;
            logic [63:0] trial;
            root = '0;
            for (int i = 63; i >= 0; i--) begin
                trial = root | (64'd1 << i);
                if ({64'd0, trial} * {64'd0, trial} <= s)
                    root = trial;
            end
            return root;
        endfunction

        function logic [31:0] scaled_unit(logic [CW-1:0] c, logic [63:0] len);
            logic [CW:0] mag;
            logic [127:0] q;
            mag = c[CW-1] ? ({1'b0, ~c} + 1'b1) : {1'b0, c};
            q = ({{(128-CW-1){1'b0}}, mag} << FRAC_SHIFT) / {64'd0, len};
            return c[CW-1] ? -q[31:0] : q[31:0];
        endfunction

        function logic [127:0] sq(logic [CW-1:0] c);
            logic [CW:0] mag;
            mag = c[CW-1] ? ({1'b0, ~c} + 1'b1) : {1'b0, c};
            return {{(128-CW-1){1'b0}}, mag} * {{(128-CW-1){1'b0}}, mag};
        endfunction

        // note an accepted input vector
        function void note_vector(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
            logic [127:0] s;
            logic [63:0] len;
            t_unit_vec e;
            s = 0;
            s = sq(x) + sq(y) + sq(z);
            len = int_sqrt(s);
            if (len <= {33'd0, thresh}) begin
                e = '{32'd0, 32'd0, 32'd0, 1'b1};
            end else begin
                e = '{scaled_unit(x, len), scaled_unit(y, len), scaled_unit(z, len), 1'b0};
            end
            pending.push_back(e);
        endfunction

        // check one result transaction
        function void check_result(logic [95:0] d, logic u);
            t_unit_vec e;
            t_unit_vec a;
            a = '{d[31:0], d[63:32], d[95:64], u};
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h %b", d, u);
                return;
            end
            e = pending.pop_front();
            if (a != e) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch exp x=%h y=%h z=%h s=%b got x=%h y=%h z=%h s=%b",
                             e.ux, e.uy, e.uz, e.short_flag, a.ux, a.uy, a.uz, a.short_flag);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [DW-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;
    logic m_axis_tuser;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    t_unit_vec_scoreboard sb = new();
    int sender_idle_pct = 12;
    int receiver_idle_pct = 12;
    bit receiver_hold = 1'b0;
    int quiet_cycles = 0;

    always #2 i_clk = ~i_clk;

    vector_normalize_3d i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // result side: random back-pressure and checking
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
        m_axis_tready <= i_rst_n && !receiver_hold &&
                         ($urandom_range(99) >= receiver_idle_pct);
    end

    // watchdog on cycles without a transaction
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[vector_normalize_3d] ERROR");
            $finish;
        end
    end

    task automatic apb_write(logic [1:0] addr, logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        sb.thresh = data[THRESH_WIDTH-1:0];
    endtask

    // offer one vector, with random idle cycles ahead of it
    task automatic send_vector(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {z, y, x};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_vector(x, y, z);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic logic [CW-1:0] rand_comp();
        case ($urandom_range(5))
            0: return $urandom_range(3) << $urandom_range(16);
            1: return -($urandom_range(255) << $urandom_range(20));
            2: return $urandom() >> $urandom_range(31);
            default: return $urandom();
        endcase
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
            send_vector(rand_comp(), rand_comp(), rand_comp());
    endtask

    localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] ONE = 1 << 16;

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero vector, extremes, unit axes, just above threshold
        send_vector(0, 0, 0);
        send_vector(1, 0, 0);
        send_vector(2, 0, 0);
        send_vector(0, 2, 0);
        send_vector(0, 0, -2);
        send_vector(CMAX, CMAX, CMAX);
        send_vector(CMIN, CMIN, CMIN);
        send_vector(CMIN, 0, 0);
        send_vector(CMAX, CMIN, 0);
        send_vector(ONE, 0, 0);
        send_vector(-ONE, ONE, -ONE);
        send_vector(3 * ONE, 4 * ONE, 0);
        send_vector(-1, -1, -1);
        send_vector(CMIN, CMAX, 1);
        send_vector(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F);
        wait_drained();

        // unmapped address, ignored by the block
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= 2'd2; pwdata <= 32'hFFFF_FFFF;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;

        // threshold at its largest, upper bit ignored
        apb_write(ADDR_THRESH, 32'hFFFF_FFFF);
        send_vector(CMAX, 0, 0);
        send_vector(CMIN, CMIN, 0);
        send_vector(32'h4000_0000, 32'h4000_0000, 32'h4000_0000);
        random_phase(200);
        wait_drained();

        // threshold zero
        apb_write(ADDR_THRESH, 32'd0);
        send_vector(1, 0, 0);
        send_vector(0, 0, 0);
        random_phase(300);

        // long receiver hold-off while input keeps coming
        fork
            begin
                receiver_hold = 1'b1;
                repeat (300) @(posedge i_clk);
                receiver_hold = 1'b0;
            end
            random_phase(200);
        join
        wait_drained();

        // mid threshold, no idling stretch
        apb_write(ADDR_THRESH, ONE);
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        random_phase(400);
        sender_idle_pct = 12;
        receiver_idle_pct = 12;
        random_phase(300);
        wait_drained();

        apb_write(ADDR_THRESH, 32'h0001_0000 * 300);
        random_phase(500);
        wait_drained();

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("[vector_normalize_3d] OK");
        else
            $display("[vector_normalize_3d] ERROR");
        $finish;
    end
endmodule

/* vector_normalize_3d.f */
+incdir+design
design/vn3d_pkg.sv
design/vn3d_div.sv
design/vector_normalize_3d.sv
tb/tb_top.sv
